// ===== hdl/sbr_pkg.sv =====
// Shared types, constants and the blending tables of the sprite blend rasterizer.
package sbr_pkg;

  localparam int unsigned SPRITE_SIDE = 8;
  localparam int unsigned SIDE_W      = $clog2(SPRITE_SIDE);
  localparam int unsigned PIX_N       = SPRITE_SIDE * SPRITE_SIDE;
  localparam int unsigned PIX_IDX_W   = $clog2(PIX_N);
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned SCR_W       = 13;
  localparam int unsigned OUT_COORD_W = 12;
  localparam int unsigned LIN_W       = 24;
  localparam int unsigned PROD_W      = 2 * SCR_W;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned COLOR_W     = 2;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [SCR_W-1:0] WIDTH_RESET  = SCR_W'(640);
  localparam logic [SCR_W-1:0] HEIGHT_RESET = SCR_W'(480);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } sbr_reg_e;

  // colour by channel index (row) and blend code (column)
  localparam logic [COLOR_W-1:0] BLEND_TAB [4][16] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
      2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
      2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
  };

  // bit n set: blend code n draws zero-channel pixels too
  localparam logic [15:0] OPAQUE_TAB = 16'b0111_1011_1101_1111;

  typedef struct packed {
    logic                opcode;
    logic                layer_sel;
    logic [COORD_W-1:0]  origin_x;
    logic [COORD_W-1:0]  origin_y;
    logic [PIX_N-1:0]    plane_low;
    logic [PIX_N-1:0]    plane_high;
    logic [CODE_W-1:0]   blend_code;
    logic                mirror_x;
    logic                mirror_y;
  } sbr_in_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] pixel_x;
    logic [OUT_COORD_W-1:0] pixel_y;
    logic [LIN_W-1:0]       linear_index;
    logic                   target_layer;
    logic [COLOR_W-1:0]     pixel_color;
    logic                   last_write;
  } sbr_out_t;

  typedef struct packed {
    logic [SCR_W-1:0] width;
    logic [SCR_W-1:0] height;
  } sbr_screen_t;

  // decoded command, pixel vectors indexed by scan position (row * side + column)
  typedef struct packed {
    logic               layer_sel;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic               mirror_x;
    logic               mirror_y;
    logic [CODE_W-1:0]  blend_code;
    logic [PIX_N-1:0]   ch_lo;
    logic [PIX_N-1:0]   ch_hi;
    logic [PIX_N-1:0]   draw;
  } sbr_cmd_t;

  // mirrored offset: side-1-idx is the bitwise inverse for a power-of-two side
  function automatic logic [SIDE_W-1:0] sprite_offset(logic [SIDE_W-1:0] idx, logic flip);
    return idx ^ {SIDE_W{flip}};
  endfunction

endpackage

// ===== hdl/sbr_cfg_regs.sv =====
// APB register file holding the screen size.
module sbr_cfg_regs import sbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output sbr_screen_t           screen_o
);

  logic [SCR_W-1:0] width_q, width_d;
  logic [SCR_W-1:0] height_q, height_d;
  logic             wr_en;
  sbr_reg_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = sbr_reg_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (reg_idx)
      REG_SCREEN_WIDTH: begin
        prdata = APB_DATA_W'(width_q);
        if (wr_en) width_d = pwdata[SCR_W-1:0];
      end
      REG_SCREEN_HEIGHT: begin
        prdata = APB_DATA_W'(height_q);
        if (wr_en) height_d = pwdata[SCR_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign screen_o = '{width: width_q, height: height_q};

endmodule

// ===== hdl/sbr_cmd_stage.sv =====
// Input register and per-pixel draw mask decode.
module sbr_cmd_stage import sbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sbr_in_t     in_data_i,
  input  sbr_screen_t screen_i,
  input  logic        load_ready_i,
  output logic        cmd_valid_o,
  output sbr_cmd_t    cmd_o
);

  logic               in_valid_q, in_valid_d;
  sbr_in_t            in_q;
  logic               accept;
  logic               opaque;
  logic [COORD_W-1:0] col_x [SPRITE_SIDE];
  logic [COORD_W-1:0] row_y [SPRITE_SIDE];
  logic [SPRITE_SIDE-1:0] col_ok, row_ok;
  logic [PIX_N-1:0]   ch_lo, ch_hi, draw;

  assign in_stall_o = in_valid_q && !load_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept)            in_valid_d = 1'b1;
    else if (load_ready_i) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  assign opaque = OPAQUE_TAB[in_q.blend_code];

  // screen test per column and per row, eight of each
  always_comb begin
    for (int i = 0; i < SPRITE_SIDE; i++) begin
      col_x[i]  = in_q.origin_x + COORD_W'(sprite_offset(SIDE_W'(i), in_q.mirror_x));
      row_y[i]  = in_q.origin_y + COORD_W'(sprite_offset(SIDE_W'(i), in_q.mirror_y));
      col_ok[i] = col_x[i] < COORD_W'(screen_i.width);
      row_ok[i] = row_y[i] < COORD_W'(screen_i.height);
    end
  end

  // planes are stored msb first; reorder to scan position
  always_comb begin
    for (int k = 0; k < PIX_N; k++) begin
      ch_lo[k] = in_q.plane_low[PIX_N-1-k];
      ch_hi[k] = in_q.opcode && in_q.plane_high[PIX_N-1-k];
      draw[k]  = (ch_lo[k] || ch_hi[k] || opaque) &&
                 col_ok[k % SPRITE_SIDE] && row_ok[k / SPRITE_SIDE];
    end
  end

  assign cmd_valid_o = in_valid_q;
  assign cmd_o = '{layer_sel:  in_q.layer_sel,
                   origin_x:   in_q.origin_x,
                   origin_y:   in_q.origin_y,
                   mirror_x:   in_q.mirror_x,
                   mirror_y:   in_q.mirror_y,
                   blend_code: in_q.blend_code,
                   ch_lo:      ch_lo,
                   ch_hi:      ch_hi,
                   draw:       draw};

endmodule

// ===== hdl/sbr_scanner.sv =====
// Pixel scanner and output register: one scan position per cycle while no drawn pixel waits on a stalled output.
module sbr_scanner import sbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  sbr_cmd_t    cmd_i,
  output logic        load_ready_o,
  input  sbr_screen_t screen_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sbr_out_t    out_data_o
);

  logic                 scan_valid_q, scan_valid_d;
  logic [PIX_IDX_W-1:0] k_q, k_d;
  logic [PIX_N-1:0]     pend_q, pend_d, pend_clr;
  sbr_cmd_t             cmd_q;
  logic                 out_valid_q, out_valid_d;
  sbr_out_t             out_q, out_d;

  logic                 cur_draw, out_free, step, is_last, done, load;
  logic [SIDE_W-1:0]    col, row;
  logic [COORD_W-1:0]   px, py;
  logic [COLOR_W-1:0]   ch;
  logic [PROD_W-1:0]    prod, lin_sum;

  assign cur_draw = pend_q[k_q];
  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = scan_valid_q && (!cur_draw || out_free);
  assign pend_clr = pend_q & ~(PIX_N'(1) << k_q);
  assign is_last  = pend_clr == '0;
  assign done     = step && is_last;

  assign load_ready_o = !scan_valid_q || done;
  // commands with nothing to draw are dropped here
  assign load         = cmd_valid_i && load_ready_o && (cmd_i.draw != '0);

  always_comb begin
    scan_valid_d = scan_valid_q;
    k_d          = k_q;
    pend_d       = pend_q;
    if (load) begin
      scan_valid_d = 1'b1;
      k_d          = '0;
      pend_d       = cmd_i.draw;
    end else if (step) begin
      scan_valid_d = !is_last;
      k_d          = k_q + 1'b1;
      pend_d       = pend_clr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_valid_q <= 1'b0;
      k_q          <= '0;
      pend_q       <= '0;
    end else begin
      scan_valid_q <= scan_valid_d;
      k_q          <= k_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= cmd_i;
  end

  // current pixel
  assign col     = k_q[SIDE_W-1:0];
  assign row     = k_q[PIX_IDX_W-1:SIDE_W];
  assign px      = cmd_q.origin_x + COORD_W'(sprite_offset(col, cmd_q.mirror_x));
  assign py      = cmd_q.origin_y + COORD_W'(sprite_offset(row, cmd_q.mirror_y));
  assign ch      = {cmd_q.ch_hi[k_q], cmd_q.ch_lo[k_q]};
  // drawn pixels sit below the screen size, so 13 bits of each coordinate suffice
  assign prod    = PROD_W'(py[SCR_W-1:0]) * PROD_W'(screen_i.width);
  assign lin_sum = prod + PROD_W'(px[SCR_W-1:0]);

  always_comb begin
    out_d = '{pixel_x:      px[OUT_COORD_W-1:0],
              pixel_y:      py[OUT_COORD_W-1:0],
              linear_index: lin_sum[LIN_W-1:0],
              target_layer: cmd_q.layer_sel,
              pixel_color:  BLEND_TAB[ch][cmd_q.blend_code],
              last_write:   is_last};
    out_valid_d = out_valid_q;
    if (step && cur_draw) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && cur_draw) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/sprite_blend_rasterizer.sv =====
// Top level of the sprite blend rasterizer.
//
// Takes one 8x8 sprite command per input transaction and emits one output
// transaction per drawn pixel, in row order, with last_write set on the final
// one. A command occupies the scanner for each scan position up to and
// including its last drawn pixel, and longer while the output side stalls;
// the scan counter steps one position per cycle unless a drawn pixel waits
// on a stalled output. A command with nothing to draw leaves the input
// register as soon as the scanner can take a command, and produces no
// output. The next command waits in the input register while the current one
// is scanned, and the output register lets the scanner skip positions that
// draw nothing while a result waits to be taken. Registers: screen_width at
// byte address 0 and screen_height at 4, 13 bits each, reset 640 and 480; they
// must be written only while the block is idle, which the block does not enforce.
//
// Datapath:
//   input register -> column/row screen tests and draw mask (64 bits)
//   scanner        -> pixel select, coordinate add, y*width multiply, blend
//   output register
module sprite_blend_rasterizer import sbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // sprite commands
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sbr_in_t               in_data_i,
  // pixel writes
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sbr_out_t              out_data_o
);

  sbr_screen_t screen;
  logic        cmd_valid;
  logic        load_ready;
  sbr_cmd_t    cmd;

  sbr_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .screen_o (screen)
  );

  // holds the next command while the scanner is busy
  sbr_cmd_stage u_cmd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .screen_i     (screen),
    .load_ready_i (load_ready),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  // walks the draw mask, skipping positions that draw nothing without a stall
  sbr_scanner u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .load_ready_o (load_ready),
    .screen_i     (screen),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hdl/sbr_checker.sv =====
// Port-level checker for the sprite blend rasterizer, bound to the top level.
module sbr_port_checker import sbr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic                  pready,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input sbr_in_t               in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input sbr_out_t              out_data_o
);

  logic [SCR_W-1:0]  width_q, height_q;
  logic              wr_en;
  logic [PROD_W-1:0] lin_ref;

  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_SCREEN_HEIGHT) height_q <= pwdata[SCR_W-1:0];
      else                               width_q  <= pwdata[SCR_W-1:0];
    end
  end

  assign lin_ref = PROD_W'(out_data_o.pixel_y) * PROD_W'(width_q) +
                   PROD_W'(out_data_o.pixel_x);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("sprite command changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("pixel write changed while stalled");

  a_x_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (width_q <= SCR_W'(4096)) |-> SCR_W'(out_data_o.pixel_x) < width_q)
    else $error("pixel write beyond screen width");

  a_y_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (height_q <= SCR_W'(4096)) |-> SCR_W'(out_data_o.pixel_y) < height_q)
    else $error("pixel write beyond screen height");

  a_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (width_q <= SCR_W'(4096)) && (height_q <= SCR_W'(4096)) |->
      out_data_o.linear_index == lin_ref[LIN_W-1:0])
    else $error("linear index does not match coordinates");

endmodule

bind sprite_blend_rasterizer sbr_port_checker u_sbr_checker (.*);

// ===== tb/sbr_checker.sv =====
// Scoreboard for the sprite blend rasterizer: predicts pixel writes and checks them.
module sbr_checker
  import sbr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  sbr_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  sbr_out_t              out_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // colour by channel index and blend code
  localparam logic [COLOR_W-1:0] COLOUR_OF [4][16] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
      2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
      2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
  };

  // blend codes that also paint zero-channel pixels
  localparam bit BLANK_DRAWN [16] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1, 0};

  logic [SCR_W-1:0] scr_width;
  logic [SCR_W-1:0] scr_height;
  sbr_out_t         pixel_writes_due [$];
  int unsigned      fails;

  task automatic report(input string msg);
    $display("[%0t] pixel write check: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // queue every pixel write one sprite command should cause, in scan order
  function automatic void rasterise(input sbr_in_t cmd);
    logic [1:0]  ch;
    logic [15:0] px;
    logic [15:0] py;
    logic [31:0] lin;
    int          pos;
    sbr_out_t    wr;
    sbr_out_t    held;
    bit          have_held;
    have_held = 1'b0;
    held      = '0;
    for (int v = 0; v < SPRITE_SIDE; v++) begin
      for (int h = 0; h < SPRITE_SIDE; h++) begin
        pos = PIX_N - 1 - (v * SPRITE_SIDE + h);
        ch  = {cmd.opcode & cmd.plane_high[pos], cmd.plane_low[pos]};
        if (ch == 2'd0 && !BLANK_DRAWN[cmd.blend_code]) continue;
        px = cmd.origin_x + 16'(cmd.mirror_x ? SPRITE_SIDE - 1 - h : h);
        py = cmd.origin_y + 16'(cmd.mirror_y ? SPRITE_SIDE - 1 - v : v);
        if (px >= 16'(scr_width) || py >= 16'(scr_height)) continue;
        lin = 32'(py) * 32'(scr_width) + 32'(px);
        wr.pixel_x      = px[OUT_COORD_W-1:0];
        wr.pixel_y      = py[OUT_COORD_W-1:0];
        wr.linear_index = lin[LIN_W-1:0];
        wr.target_layer = cmd.layer_sel;
        wr.pixel_color  = COLOUR_OF[ch][cmd.blend_code];
        wr.last_write   = 1'b0;
        if (have_held) pixel_writes_due.push_back(held);
        held      = wr;
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last_write = 1'b1;
      pixel_writes_due.push_back(held);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sbr_out_t due;
    if (!rst_ni) begin
      scr_width  = WIDTH_RESET;
      scr_height = HEIGHT_RESET;
      fails      = 0;
      pixel_writes_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (sbr_reg_e'(paddr_i[2]))
          REG_SCREEN_WIDTH:  scr_width  = pwdata_i[SCR_W-1:0];
          REG_SCREEN_HEIGHT: scr_height = pwdata_i[SCR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rasterise(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (pixel_writes_due.size() == 0) begin
          report($sformatf("unexpected write at x %0d y %0d",
                           out_data_i.pixel_x, out_data_i.pixel_y));
        end else begin
          due = pixel_writes_due.pop_front();
          check_field("pixel_x", out_data_i.pixel_x, due.pixel_x);
          check_field("pixel_y", out_data_i.pixel_y, due.pixel_y);
          check_field("linear_index", out_data_i.linear_index, due.linear_index);
          check_field("target_layer", out_data_i.target_layer, due.target_layer);
          check_field("pixel_color", out_data_i.pixel_color, due.pixel_color);
          check_field("last_write", out_data_i.last_write, due.last_write);
        end
      end
    end
    fail_count_o = fails;
    pending_o    = pixel_writes_due.size();
  end

endmodule

// ===== tb/sprite_blend_rasterizer_tb.sv =====
// Testbench top for the sprite blend rasterizer: stimulus, back-pressure and verdict.
module sprite_blend_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbr_pkg::*;

  // receiver back-pressure styles, each held for a random stretch
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  sbr_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  sbr_out_t              out_data_o;

  int unsigned fail_count;
  int unsigned pending;

  // screen size last programmed, steers where random sprites land
  int unsigned scr_w_now = 640;
  int unsigned scr_h_now = 480;

  // sender burst bookkeeping
  int unsigned burst_left = 0;
  int unsigned gap_len    = 0;

  // set by the stimulus to ask the stall process for one long hold-off
  bit long_hold_req = 1'b0;

  sprite_blend_rasterizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  sbr_checker pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // reset asserted from the start, released on a falling edge
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // watchdog: a generous multiple of the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver back-pressure. Switches between styles at random so stalls land
  // on every phase of the scan; a long hold-off, when asked for, is counted
  // here so the sender keeps offering and the block backs up to its input.
  initial begin : stall_gen
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 400;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          STALL_NONE:     out_stall_i = 1'b0;
          STALL_LIGHT:    out_stall_i = ($urandom_range(0, 99) < 30);
          STALL_HEAVY:    out_stall_i = ($urandom_range(0, 99) < 75);
          STALL_PERIODIC: out_stall_i = (mode_left % 4 == 0);
          default:        out_stall_i = 1'b0;
        endcase
      end
    end
  end

  // One register write: setup cycle then access cycle. Called on a falling edge.
  task automatic apb_write(input sbr_reg_e which, input int unsigned value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {which, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h);
    apb_write(REG_SCREEN_WIDTH, w);
    apb_write(REG_SCREEN_HEIGHT, h);
    scr_w_now = w;
    scr_h_now = h;
  endtask

  // Offer one sprite command and hold it until taken. Outside back-to-back
  // mode the sender works in bursts with random gaps between them.
  task automatic send_sprite(input sbr_in_t cmd, input bit back_to_back);
    if (!back_to_back) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_len    = $urandom_range(0, 6);
        if (gap_len != 0) begin
          in_valid_i = 1'b0;
          repeat (gap_len) @(negedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i = 1'b1;
    in_data_i  = cmd;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Wait until every predicted write has arrived, then let trailing commands
  // that draw nothing clear the block before the registers are touched.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // mostly near the visible area, with some far away and some wrapping past 0xFFFF
  function automatic logic [15:0] random_origin(input int unsigned extent);
    case ($urandom_range(0, 9))
      7, 8:    return 16'($urandom());
      9:       return 16'hFFF0 + 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, extent + 8)) - 16'd4;
    endcase
  endfunction

  function automatic logic [63:0] random_plane();
    logic [63:0] a;
    logic [63:0] b;
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0:       return a & b;   // sparse, many transparent pixels
      1:       return a | b;   // dense
      2:       return '0;
      3:       return '1;
      default: return a;
    endcase
  endfunction

  function automatic sbr_in_t random_sprite();
    sbr_in_t s;
    s.opcode     = 1'($urandom());
    s.layer_sel  = 1'($urandom());
    s.origin_x   = random_origin(scr_w_now);
    s.origin_y   = random_origin(scr_h_now);
    s.plane_low  = random_plane();
    s.plane_high = random_plane();
    s.blend_code = CODE_W'($urandom());
    s.mirror_x   = 1'($urandom());
    s.mirror_y   = 1'($urandom());
    return s;
  endfunction

  // Directed sprites for the reset screen of 640x480. Item n uses blend code n,
  // so every code is seen; codes 5, 10 and 15 are the see-through ones.
  function automatic sbr_in_t directed_sprite(input int unsigned idx);
    sbr_in_t s;
    s            = '0;
    s.opcode     = 1'b1;
    s.layer_sel  = idx[0];
    s.blend_code = CODE_W'(idx);
    s.plane_low  = {$urandom(), $urandom()};
    s.plane_high = {$urandom(), $urandom()};
    case (idx)
      // opaque code on a blank one-bit plane: full square of background colour
      0: begin s.opcode = 1'b0; s.plane_low = '0; end
      // one-bit mode must ignore a full second plane
      1: begin s.opcode = 1'b0; s.plane_low = '1; s.plane_high = '1; end
      2: begin s.plane_low = {8{8'hAA}}; s.plane_high = {8{8'hCC}}; s.mirror_x = 1'b1; end
      3: s.mirror_y = 1'b1;
      // origin at 0xFFFF: mirrored offsets wrap round to column and line 0
      4: begin s.origin_x = '1; s.origin_y = '1; s.mirror_x = 1'b1; s.mirror_y = 1'b1; end
      // see-through code with a blank plane: nothing drawn, no last flag
      5: begin s.opcode = 1'b0; s.plane_low = '0; end
      // straddles the bottom right screen corner
      6: begin s.origin_x = 16'd636; s.origin_y = 16'd476; end
      // wholly right of the screen
      7: s.origin_x = 16'd640;
      // only the last scan position set; code 8 still paints the blank ones
      8: begin s.opcode = 1'b0; s.plane_low = 64'd1; end
      // only the first scan position set, on the last line; code 9 still paints the blank ones of that line
      9: begin s.opcode = 1'b0; s.plane_low = {1'b1, 63'd0}; s.origin_y = 16'd479; end
      10: begin s.plane_low = '0; s.plane_high = '0; end
      11: begin s.plane_low = '0; s.plane_high = '1; s.origin_x = 16'd100; s.origin_y = 16'd200; end
      // top of the 16-bit range, no wrap: all off-screen
      12: s.origin_x = 16'hFFF8;
      // partial wrap on both axes
      13: begin s.origin_x = 16'hFFFC; s.origin_y = 16'hFFFA; end
      // fills the screen corner exactly
      14: begin s.origin_x = 16'd632; s.origin_y = 16'd472; end
      default: begin
        s.plane_low  = '1;
        s.plane_high = '1;
        s.mirror_x   = 1'b1;
        s.mirror_y   = 1'b1;
      end
    endcase
    return s;
  endfunction

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned n);
    set_screen(w, h);
    repeat (n) send_sprite(random_sprite(), 1'b0);
    wait_idle();
  endtask

  // Main sequence. Runs first at the reset screen size, then sweeps the size
  // registers through their extremes: single pixel, the full 4096 range, the
  // all-ones value beyond range (coordinates and index get truncated), zero
  // on each axis, a small odd size and a random one.
  initial begin : stimulus
    @(posedge rst_ni);
    @(negedge clk_i);

    for (int unsigned i = 0; i < 16; i++) send_sprite(directed_sprite(i), 1'b0);

    // long receiver hold-off while the sender pushes without gaps
    long_hold_req = 1'b1;
    repeat (30) send_sprite(random_sprite(), 1'b1);
    repeat (40) send_sprite(random_sprite(), 1'b0);
    wait_idle();

    run_phase(1, 1, 20);
    run_phase(4096, 4096, 10);
    run_phase(8191, 8191, 30);
    run_phase(0, 8191, 8);
    run_phase(300, 0, 6);
    run_phase(13, 9, 40);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 30);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
